// ----- rtl/packed_glyph_row_unpacker_defines.svh -----
// Assertion macros shared by the glyph row unpacker RTL.
`ifndef PACKED_GLYPH_ROW_UNPACKER_DEFINES_SVH
`define PACKED_GLYPH_ROW_UNPACKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PGRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgru: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PGRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgru: next-cycle check failed");

`endif

// ----- rtl/pgru_pkg.sv -----
// Shared constants for the packed glyph row unpacker.
`default_nettype none

package pgru_pkg;

    // Store depths and row limit.
    localparam int FONT_WORDS    = 4096;
    localparam int GLYPH_ENTRIES = 256;
    localparam int MAX_ROWS      = 64;

    // Derived widths.
    localparam int FONT_AW   = $clog2(FONT_WORDS);
    localparam int GLYPH_AW  = $clog2(GLYPH_ENTRIES);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS);
    localparam int WORD_W    = 32;
    localparam int ENTRY_W   = 23;
    localparam int SIZE_W    = 13;
    localparam int CFG_DW    = 10;
    localparam int CFG_IW    = 2;

    // Command codes.
    localparam logic [1:0] CMD_LOAD_FONT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_GLYPH = 2'd1;
    localparam logic [1:0] CMD_DRAW       = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_PROP_MODE    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MONO_WIDTH   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MONO_BLOCK   = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_GLYPH_HEIGHT = 2'd3;

    // Register reset values.
    localparam logic [5:0] MONO_WIDTH_RST   = 6'd8;
    localparam logic [9:0] MONO_BLOCK_RST   = 10'd64;
    localparam logic [6:0] GLYPH_HEIGHT_RST = 7'd8;

    // Widest glyph a row mask can carry.
    localparam logic [5:0] MAX_GLYPH_WIDTH = 6'd32;

endpackage

`default_nettype wire

// ----- rtl/pgru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pgru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/packed_glyph_row_unpacker.sv -----
// Top level of the packed glyph row unpacker: command intake, bit walker and result register.
// Loads and unused commands are taken in ST_IDLE; a draw does the table lookup in ST_GEOM, then per
// row a font read, a 32-bit serial walk, an extra read when the row crosses a word mid-row and an emit.
// The serial bit walker sets the rate: one bit per cycle in ST_SHIFT, paused by reads and held emits.
// Reset clears the control state and sets the registers to their defaults; both stores start
// undefined and must be loaded before they are read.
`default_nettype none
`include "packed_glyph_row_unpacker_defines.svh"

module packed_glyph_row_unpacker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration write port.
    input  wire logic                         cfg_we,
    input  wire logic [pgru_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [pgru_pkg::CFG_DW-1:0]  cfg_wdata,
    // Command channel.
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   command,
    input  wire logic [11:0]                  word_address,
    input  wire logic [pgru_pkg::WORD_W-1:0]  word_data,
    input  wire logic [7:0]                   entry_index,
    input  wire logic [5:0]                   entry_width,
    input  wire logic [4:0]                   entry_bit_offset,
    input  wire logic [11:0]                  entry_word,
    input  wire logic [9:0]                   cursor_x,
    input  wire logic [9:0]                   cursor_y,
    input  wire logic [5:0]                   advance,
    // Row result channel.
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [9:0]                        row_x,
    output logic [10:0]                       row_y,
    output logic [pgru_pkg::WORD_W-1:0]       row_mask,
    output logic [5:0]                        row_width,
    output logic                              last_row,
    output logic [10:0]                       next_cursor_x
);

    import pgru_pkg::*;

    // Walker states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GEOM  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [ROW_CNT_W-1:0] ROW_LAST = ROW_CNT_W'(MAX_ROWS - 1);

    // Control state.
    logic [2:0]           state_reg, state_next;
    logic                 prop_mode_reg;
    logic [5:0]           mono_width_reg;
    logic [9:0]           mono_block_reg;
    logic [6:0]           glyph_height_reg;
    logic                 out_valid_reg, out_valid_next;

    // Draw context and walker datapath.
    logic [9:0]           cx_reg, cx_next;
    logic [9:0]           cy_reg, cy_next;
    logic [5:0]           adv_reg, adv_next;
    logic [7:0]           idx_reg, idx_next;
    logic [5:0]           width_reg, width_next;
    logic [SIZE_W-1:0]    remain_reg, remain_next;
    logic [FONT_AW-1:0]   word_addr_reg, word_addr_next;
    logic [4:0]           bit_ptr_reg, bit_ptr_next;
    logic [4:0]           shift_cnt_reg, shift_cnt_next;
    logic [ROW_CNT_W-1:0] row_reg, row_next;
    logic [WORD_W-1:0]    mask_reg, mask_next;

    // Result register.
    logic [9:0]           row_x_reg, row_x_next;
    logic [10:0]          row_y_reg, row_y_next;
    logic [WORD_W-1:0]    row_mask_reg, row_mask_next;
    logic [5:0]           row_width_reg, row_width_next;
    logic                 last_row_reg, last_row_next;
    logic [10:0]          next_cx_reg, next_cx_next;

    // Memory ports.
    logic                 font_we, font_re;
    logic [WORD_W-1:0]    font_rdata;
    logic                 tbl_we, tbl_re;
    logic [ENTRY_W-1:0]   tbl_rdata;

    // Geometry and walker helpers.
    logic                 in_xfer;
    logic                 out_free;
    logic [5:0]           tbl_width_sat;
    logic [5:0]           mono_width_sat;
    logic [SIZE_W-1:0]    prop_size;
    logic [17:0]          mono_pos;
    logic [5:0]           geo_width;
    logic [SIZE_W-1:0]    geo_size;
    logic [FONT_AW-1:0]   geo_base;
    logic [4:0]           geo_bit;
    logic [5:0]           row_w;
    logic                 bit_live;
    logic                 font_bit;
    logic                 row_is_last;

    // Stores.
    pgru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FONT_WORDS)
    ) u_font_ram (
        .clk   (clk),
        .we    (font_we),
        .waddr (word_address[FONT_AW-1:0]),
        .wdata (word_data),
        .re    (font_re),
        .raddr (word_addr_reg),
        .rdata (font_rdata)
    );

    pgru_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GLYPH_ENTRIES)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (entry_index[GLYPH_AW-1:0]),
        .wdata ({entry_width, entry_bit_offset, entry_word}),
        .re    (tbl_re),
        .raddr (entry_index[GLYPH_AW-1:0]),
        .rdata (tbl_rdata)
    );

    // Command intake: a command is taken only while the walker is idle.
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid & in_ready;
    assign font_we  = in_xfer & (command == CMD_LOAD_FONT);
    assign tbl_we   = in_xfer & (command == CMD_LOAD_GLYPH);
    assign tbl_re   = in_xfer & (command == CMD_DRAW);
    assign font_re  = (state_reg == ST_RD);
    assign out_free = ~out_valid_reg | out_ready;

    // Glyph geometry, one multiplier per mode.
    assign tbl_width_sat  = (tbl_rdata[22:17] > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH
                                                                 : tbl_rdata[22:17];
    assign mono_width_sat = (mono_width_reg > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH
                                                               : mono_width_reg;
    assign prop_size = {7'd0, tbl_width_sat} * {6'd0, glyph_height_reg};
    assign mono_pos  = {8'd0, mono_block_reg} * {10'd0, idx_reg};

    always_comb
    begin
        if (prop_mode_reg)
        begin
            geo_width = tbl_width_sat;
            geo_size  = prop_size;
            geo_base  = tbl_rdata[FONT_AW-1:0];
            geo_bit   = tbl_rdata[16:12];
        end
        else
        begin
            geo_width = mono_width_sat;
            geo_size  = SIZE_W'(mono_block_reg);
            geo_base  = mono_pos[FONT_AW+4:5];
            geo_bit   = mono_pos[4:0];
        end
    end

    // Current row width, bit selection and last-row test.
    assign row_w       = (remain_reg < SIZE_W'(width_reg)) ? remain_reg[5:0] : width_reg;
    assign bit_live    = ({1'b0, shift_cnt_reg} < row_w);
    assign font_bit    = font_rdata[~bit_ptr_reg];
    assign row_is_last = (remain_reg <= SIZE_W'(width_reg)) | (row_reg == ROW_LAST);

    // Walker sequencing.
    always_comb
    begin
        state_next     = state_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        adv_next       = adv_reg;
        idx_next       = idx_reg;
        width_next     = width_reg;
        remain_next    = remain_reg;
        word_addr_next = word_addr_reg;
        bit_ptr_next   = bit_ptr_reg;
        shift_cnt_next = shift_cnt_reg;
        row_next       = row_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        row_x_next     = row_x_reg;
        row_y_next     = row_y_reg;
        row_mask_next  = row_mask_reg;
        row_width_next = row_width_reg;
        last_row_next  = last_row_reg;
        next_cx_next   = next_cx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (tbl_re)
                begin
                    cx_next    = cursor_x;
                    cy_next    = cursor_y;
                    adv_next   = advance;
                    idx_next   = entry_index;
                    state_next = ST_GEOM;
                end
            end
            ST_GEOM:
            begin
                width_next     = geo_width;
                remain_next    = geo_size;
                word_addr_next = geo_base;
                bit_ptr_next   = geo_bit;
                shift_cnt_next = 5'd0;
                row_next       = '0;
                if ((geo_width == 6'd0) || (geo_size == '0))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // One bit per cycle into the top of the mask; padding cycles shift in zeros.
                mask_next      = {bit_live & font_bit, mask_reg[WORD_W-1:1]};
                shift_cnt_next = shift_cnt_reg + 5'd1;
                if (bit_live)
                begin
                    bit_ptr_next = bit_ptr_reg + 5'd1;
                end
                if (shift_cnt_reg == 5'd31)
                begin
                    state_next = ST_EMIT;
                end
                else if (bit_live && (bit_ptr_reg == 5'd31))
                begin
                    state_next = ST_RD;
                end
                if (bit_live && (bit_ptr_reg == 5'd31))
                begin
                    word_addr_next = word_addr_reg + FONT_AW'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    row_x_next     = cx_reg;
                    row_y_next     = {1'b0, cy_reg} + 11'(row_reg);
                    row_mask_next  = mask_reg;
                    row_width_next = row_w;
                    last_row_next  = row_is_last;
                    next_cx_next   = {1'b0, cx_reg} + 11'(adv_reg);
                    remain_next    = remain_reg - SIZE_W'(width_reg);
                    row_next       = row_reg + ROW_CNT_W'(1);
                    if (row_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            prop_mode_reg    <= 1'b0;
            mono_width_reg   <= MONO_WIDTH_RST;
            mono_block_reg   <= MONO_BLOCK_RST;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROP_MODE:    prop_mode_reg    <= cfg_wdata[0];
                    CFG_MONO_WIDTH:   mono_width_reg   <= cfg_wdata[5:0];
                    CFG_MONO_BLOCK:   mono_block_reg   <= cfg_wdata[9:0];
                    CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_wdata[6:0];
                    default:          prop_mode_reg    <= prop_mode_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        adv_reg       <= adv_next;
        idx_reg       <= idx_next;
        width_reg     <= width_next;
        remain_reg    <= remain_next;
        word_addr_reg <= word_addr_next;
        bit_ptr_reg   <= bit_ptr_next;
        shift_cnt_reg <= shift_cnt_next;
        row_reg       <= row_next;
        mask_reg      <= mask_next;
        row_x_reg     <= row_x_next;
        row_y_reg     <= row_y_next;
        row_mask_reg  <= row_mask_next;
        row_width_reg <= row_width_next;
        last_row_reg  <= last_row_next;
        next_cx_reg   <= next_cx_next;
    end

    // Result outputs.
    assign out_valid     = out_valid_reg;
    assign row_x         = row_x_reg;
    assign row_y         = row_y_reg;
    assign row_mask      = row_mask_reg;
    assign row_width     = row_width_reg;
    assign last_row      = last_row_reg;
    assign next_cursor_x = next_cx_reg;

    // Checks on the walker and result register.
    `PGRU_ASSERT_IMPL(a_row_width_range, clk, rst_n, out_valid_reg,
        (row_width_reg != 6'd0) && (row_width_reg <= MAX_GLYPH_WIDTH))
    `PGRU_ASSERT_IMPL(a_mask_above_width_clear, clk, rst_n, out_valid_reg,
        (row_mask_reg >> row_width_reg) == '0)
    `PGRU_ASSERT_NEXT(a_last_row_ends_draw, clk, rst_n,
        (state_reg == ST_EMIT) && out_free && row_is_last,
        (state_reg == ST_IDLE) && out_valid_reg && last_row_reg)

endmodule

`default_nettype wire

// ----- tb/tb_packed_glyph_row_unpacker.sv -----
// Self-checking testbench for the packed glyph row unpacker: loads, draws and row mask checks.
`timescale 1ns / 1ps

module tb_packed_glyph_row_unpacker;

    import pgru_pkg::*;

    // The command encoding that the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Cycles allowed for a load still in flight before a register write, and at the end.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned TAIL_CYCLES   = 100;
    localparam int unsigned HOLD_CYCLES   = 3000;
    localparam int unsigned TIMEOUT_NS    = 100_000_000;

    typedef enum {
        TRAFFIC_SMOOTH,
        TRAFFIC_SENDER_GAPS,
        TRAFFIC_RECEIVER_STALLS,
        TRAFFIC_BOTH
    } traffic_mode_t;

    // One command as offered on the input channel.
    typedef struct {
        logic [1:0]  command;
        logic [11:0] word_address;
        logic [31:0] word_data;
        logic [7:0]  entry_index;
        logic [5:0]  entry_width;
        logic [4:0]  entry_bit_offset;
        logic [11:0] entry_word;
        logic [9:0]  cursor_x;
        logic [9:0]  cursor_y;
        logic [5:0]  advance;
    } glyph_cmd_t;

    // One emitted glyph row.
    typedef struct {
        logic [9:0]  row_x;
        logic [10:0] row_y;
        logic [31:0] row_mask;
        logic [5:0]  row_width;
        logic        last_row;
        logic [10:0] next_cursor_x;
    } glyph_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          command;
    logic [11:0]         word_address;
    logic [WORD_W-1:0]   word_data;
    logic [7:0]          entry_index;
    logic [5:0]          entry_width;
    logic [4:0]          entry_bit_offset;
    logic [11:0]         entry_word;
    logic [9:0]          cursor_x;
    logic [9:0]          cursor_y;
    logic [5:0]          advance;
    logic                out_valid;
    logic                out_ready;
    logic [9:0]          row_x;
    logic [10:0]         row_y;
    logic [WORD_W-1:0]   row_mask;
    logic [5:0]          row_width;
    logic                last_row;
    logic [10:0]         next_cursor_x;

    // Mirror of the font store, the glyph table and the registers.
    logic [31:0] font_mem [FONT_WORDS];
    bit          font_known [FONT_WORDS];
    logic [5:0]  entry_width_mem [GLYPH_ENTRIES];
    logic [4:0]  entry_offset_mem [GLYPH_ENTRIES];
    logic [11:0] entry_word_mem [GLYPH_ENTRIES];
    bit          entry_known [GLYPH_ENTRIES];
    logic        shadow_prop_mode    = 1'b0;
    logic [5:0]  shadow_mono_width   = MONO_WIDTH_RST;
    logic [9:0]  shadow_mono_block   = MONO_BLOCK_RST;
    logic [6:0]  shadow_glyph_height = GLYPH_HEIGHT_RST;

    glyph_row_t  pending_rows [$];
    glyph_row_t  head_row;
    int unsigned fail_count     = 0;
    int unsigned items_sent     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;

    packed_glyph_row_unpacker DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .word_address     (word_address),
        .word_data        (word_data),
        .entry_index      (entry_index),
        .entry_width      (entry_width),
        .entry_bit_offset (entry_bit_offset),
        .entry_word       (entry_word),
        .cursor_x         (cursor_x),
        .cursor_y         (cursor_y),
        .advance          (advance),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .row_x            (row_x),
        .row_y            (row_y),
        .row_mask         (row_mask),
        .row_width        (row_width),
        .last_row         (last_row),
        .next_cursor_x    (next_cursor_x)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Width, size, base word and start bit of a glyph under the current settings.
    task automatic glyph_geometry(input logic [7:0] index, output int unsigned width,
                                  output int unsigned size, output int unsigned base,
                                  output int unsigned start_bit);
        int unsigned pos;
        if (shadow_prop_mode)
        begin
            width     = entry_width_mem[index];
            if (width > MAX_GLYPH_WIDTH)
                width = MAX_GLYPH_WIDTH;
            start_bit = entry_offset_mem[index];
            base      = entry_word_mem[index];
            size      = width * shadow_glyph_height;
        end
        else
        begin
            width     = shadow_mono_width;
            if (width > MAX_GLYPH_WIDTH)
                width = MAX_GLYPH_WIDTH;
            size      = shadow_mono_block;
            pos       = size * index;
            base      = pos / WORD_W;
            start_bit = pos % WORD_W;
        end
    endtask

    // Updates the mirrored stores and queues the rows that an accepted command draws.
    task automatic predict_glyph_rows(input glyph_cmd_t c);
        int unsigned width, size, base, start_bit, rows, valid_px, pos, r, i;
        glyph_row_t  row;
        case (c.command)
            CMD_LOAD_FONT:
            begin
                font_mem[c.word_address]   = c.word_data;
                font_known[c.word_address] = 1'b1;
            end
            CMD_LOAD_GLYPH:
            begin
                entry_width_mem[c.entry_index]  = c.entry_width;
                entry_offset_mem[c.entry_index] = c.entry_bit_offset;
                entry_word_mem[c.entry_index]   = c.entry_word;
                entry_known[c.entry_index]      = 1'b1;
            end
            CMD_DRAW:
            begin
                glyph_geometry(c.entry_index, width, size, base, start_bit);
                if (width != 0 && size != 0)
                begin
                    rows = (size + width - 1) / width;
                    if (rows > MAX_ROWS)
                        rows = MAX_ROWS;
                    for (r = 0; r < rows; r++)
                    begin
                        valid_px = size - r * width;
                        if (valid_px > width)
                            valid_px = width;
                        row.row_mask = '0;
                        // Bits are read most significant first, across word boundaries.
                        for (i = 0; i < valid_px; i++)
                        begin
                            pos = start_bit + r * width + i;
                            row.row_mask[i] =
                                font_mem[(base + pos / WORD_W) % FONT_WORDS][WORD_W - 1 - pos % WORD_W];
                        end
                        row.row_x         = c.cursor_x;
                        row.row_y         = 11'(c.cursor_y + r);
                        row.row_width     = 6'(valid_px);
                        row.last_row      = (r + 1 == rows);
                        row.next_cursor_x = 11'(c.cursor_x) + 11'(c.advance);
                        pending_rows.push_back(row);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // A command with every data field random and the unused command code; callers then fix what matters.
    function automatic glyph_cmd_t random_cmd();
        glyph_cmd_t c;
        c.command          = CMD_UNUSED;
        c.word_address     = 12'($urandom);
        c.word_data        = $urandom;
        c.entry_index      = 8'($urandom);
        c.entry_width      = 6'($urandom);
        c.entry_bit_offset = 5'($urandom);
        c.entry_word       = 12'($urandom);
        c.cursor_x         = 10'($urandom);
        c.cursor_y         = 10'($urandom);
        c.advance          = 6'($urandom);
        return c;
    endfunction

    // Mostly ordinary widths, sometimes zero or beyond the widest row.
    function automatic logic [5:0] random_entry_width();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 6'd0;
        else if (pick < 12)
            return 6'($urandom_range(63, 33));
        return 6'($urandom_range(32, 1));
    endfunction

    // Offers one command and waits for its transfer; valid stays high on return.
    task automatic send_item(input glyph_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        command          <= c.command;
        word_address     <= c.word_address;
        word_data        <= c.word_data;
        entry_index      <= c.entry_index;
        entry_width      <= c.entry_width;
        entry_bit_offset <= c.entry_bit_offset;
        entry_word       <= c.entry_word;
        cursor_x         <= c.cursor_x;
        cursor_y         <= c.cursor_y;
        advance          <= c.advance;
        do
            @(posedge clk);
        while (!in_ready);
        predict_glyph_rows(c);
        if (c.command != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_font_word(input logic [11:0] address, input logic [31:0] data);
        glyph_cmd_t c;
        c              = random_cmd();
        c.command      = CMD_LOAD_FONT;
        c.word_address = address;
        c.word_data    = data;
        send_item(c);
    endtask

    task automatic send_glyph_entry(input logic [7:0] index, input logic [5:0] width,
                                    input logic [4:0] offset, input logic [11:0] word);
        glyph_cmd_t c;
        c                  = random_cmd();
        c.command          = CMD_LOAD_GLYPH;
        c.entry_index      = index;
        c.entry_width      = width;
        c.entry_bit_offset = offset;
        c.entry_word       = word;
        send_item(c);
    endtask

    task automatic send_unused();
        glyph_cmd_t c;
        c = random_cmd();
        send_item(c);
    endtask

    // Loads whatever the glyph will touch that was never written, then draws it.
    task automatic draw_glyph(input logic [7:0] index, input logic [9:0] x,
                              input logic [9:0] y, input logic [5:0] step);
        glyph_cmd_t  c;
        int unsigned width, size, base, start_bit, nbits, span, addr, k;
        if (shadow_prop_mode && !entry_known[index])
            send_glyph_entry(index, random_entry_width(), 5'($urandom), 12'($urandom));
        glyph_geometry(index, width, size, base, start_bit);
        if (width == 0 || size == 0)
            nbits = 1;
        else
            nbits = (size < MAX_ROWS * width) ? size : MAX_ROWS * width;
        // One word past the last bit as well, in case the walker reads ahead.
        span = (start_bit + nbits - 1) / WORD_W + 1;
        for (k = 0; k <= span; k++)
        begin
            addr = (base + k) % FONT_WORDS;
            if (!font_known[addr])
                send_font_word(12'(addr), $urandom);
        end
        c             = random_cmd();
        c.command     = CMD_DRAW;
        c.entry_index = index;
        c.cursor_x    = x;
        c.cursor_y    = y;
        c.advance     = step;
        send_item(c);
    endtask

    task automatic draw_random_glyph();
        draw_glyph(8'($urandom), 10'($urandom), 10'($urandom), 6'($urandom));
    endtask

    // Drops valid and waits until every queued row has been received.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rows.size() != 0)
            @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_register(input logic [CFG_IW-1:0] index,
                                  input logic [CFG_DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        case (index)
            CFG_PROP_MODE:    shadow_prop_mode    = value[0];
            CFG_MONO_WIDTH:   shadow_mono_width   = value[5:0];
            CFG_MONO_BLOCK:   shadow_mono_block   = value[9:0];
            CFG_GLYPH_HEIGHT: shadow_glyph_height = value[6:0];
            default:
            begin
            end
        endcase
    endtask

    // Writes all four registers once the block has gone quiet.
    task automatic apply_settings(input logic prop, input logic [5:0] mono_w,
                                  input logic [9:0] mono_block, input logic [6:0] height);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_PROP_MODE, CFG_DW'(prop));
        write_register(CFG_MONO_WIDTH, CFG_DW'(mono_w));
        write_register(CFG_MONO_BLOCK, mono_block);
        write_register(CFG_GLYPH_HEIGHT, CFG_DW'(height));
        cfg_we <= 1'b0;
    endtask

    task automatic set_traffic(input traffic_mode_t mode);
        case (mode)
            TRAFFIC_SMOOTH:          begin send_idle_pct = 0;  stall_pct = 0;  end
            TRAFFIC_SENDER_GAPS:     begin send_idle_pct = 62; stall_pct = 0;  end
            TRAFFIC_RECEIVER_STALLS: begin send_idle_pct = 0;  stall_pct = 62; end
            default:                 begin send_idle_pct = 7;  stall_pct = 7;  end
        endcase
    endtask

    // Reset geometry: eight pixels wide, 64 bits per glyph, cursor extremes.
    task automatic test_mono_defaults();
        send_font_word(12'd0, 32'hffff_ffff);
        send_font_word(12'd1, 32'h0000_0000);
        draw_glyph(8'd0, 10'd0, 10'd0, 6'd0);
        draw_glyph(8'd255, 10'd1023, 10'd1023, 6'd63);
        send_unused();
        send_font_word(12'd4095, 32'h8000_0001);
    endtask

    // Zero width, zero size, saturated width and row clipping in monospace mode.
    task automatic test_mono_corner_cases();
        apply_settings(1'b0, 6'd0, 10'd64, 7'd8);
        draw_glyph(8'd0, 10'd5, 10'd7, 6'd3);
        apply_settings(1'b0, 6'd8, 10'd0, 7'd8);
        draw_glyph(8'd0, 10'd5, 10'd7, 6'd3);
        apply_settings(1'b0, 6'd63, 10'd100, 7'd8);
        draw_glyph(8'd0, 10'd512, 10'd300, 6'd40);
        apply_settings(1'b0, 6'd1, 10'd512, 7'd8);
        draw_glyph(8'd0, 10'd1, 10'd960, 6'd1);
    endtask

    // Table-driven glyphs: wrap past the store end, zero width, saturated width, zero height, clipping.
    task automatic test_proportional_table();
        apply_settings(1'b1, 6'd8, 10'd64, 7'd4);
        send_glyph_entry(8'd255, 6'd32, 5'd17, 12'd4095);
        draw_glyph(8'd255, 10'd100, 10'd200, 6'd32);
        send_glyph_entry(8'd1, 6'd0, 5'd0, 12'd0);
        draw_glyph(8'd1, 10'd100, 10'd200, 6'd0);
        send_glyph_entry(8'd2, 6'd63, 5'd31, 12'd0);
        draw_glyph(8'd2, 10'd1023, 10'd0, 6'd63);
        apply_settings(1'b1, 6'd8, 10'd64, 7'd0);
        draw_glyph(8'd2, 10'd0, 10'd0, 6'd1);
        apply_settings(1'b1, 6'd8, 10'd64, 7'd127);
        send_glyph_entry(8'd3, 6'd1, 5'd0, 12'd4);
        draw_glyph(8'd3, 10'd9, 10'd1023, 6'd9);
    endtask

    // Mostly load-then-draw sequences, with stray loads and ignored commands mixed in.
    task automatic test_random_traffic(input int unsigned count, input traffic_mode_t mode);
        int unsigned start, pick;
        set_traffic(mode);
        start = items_sent;
        while (items_sent - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                draw_random_glyph();
            else if (pick < 85)
                send_font_word(12'($urandom), $urandom);
            else if (pick < 95)
                send_glyph_entry(8'($urandom), random_entry_width(), 5'($urandom),
                                 12'($urandom));
            else
                send_unused();
        end
    endtask

    // The receiver holds off while draws keep coming, then the sender waits for a drain.
    task automatic test_backpressure();
        set_traffic(TRAFFIC_SMOOTH);
        hold_requests++;
        repeat (8) draw_random_glyph();
        wait_drained();
        repeat (6) draw_random_glyph();
    endtask

    // Result receiver: random stalls, plus long hold-offs on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Each row transfer is compared with the oldest queued row.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("row with none pending: row_x %0d row_y %0d", row_x, row_y);
                fail_count++;
            end
            else
            begin
                head_row = pending_rows.pop_front();
                if (row_x !== head_row.row_x)
                begin
                    $error("row_x: expected %0d, actual %0d", head_row.row_x, row_x);
                    fail_count++;
                end
                if (row_y !== head_row.row_y)
                begin
                    $error("row_y: expected %0d, actual %0d", head_row.row_y, row_y);
                    fail_count++;
                end
                if (row_mask !== head_row.row_mask)
                begin
                    $error("row_mask: expected %h, actual %h", head_row.row_mask, row_mask);
                    fail_count++;
                end
                if (row_width !== head_row.row_width)
                begin
                    $error("row_width: expected %0d, actual %0d", head_row.row_width, row_width);
                    fail_count++;
                end
                if (last_row !== head_row.last_row)
                begin
                    $error("last_row: expected %0d, actual %0d", head_row.last_row, last_row);
                    fail_count++;
                end
                if (next_cursor_x !== head_row.next_cursor_x)
                begin
                    $error("next_cursor_x: expected %0d, actual %0d",
                           head_row.next_cursor_x, next_cursor_x);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int unsigned pick_width;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_PROP_MODE;
        cfg_wdata        = '0;
        in_valid         = 1'b0;
        command          = CMD_LOAD_FONT;
        word_address     = '0;
        word_data        = '0;
        entry_index      = '0;
        entry_width      = '0;
        entry_bit_offset = '0;
        entry_word       = '0;
        cursor_x         = '0;
        cursor_y         = '0;
        advance          = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_traffic(TRAFFIC_SMOOTH);
        test_mono_defaults();
        test_mono_corner_cases();
        test_proportional_table();

        apply_settings(1'b0, MONO_WIDTH_RST, MONO_BLOCK_RST, GLYPH_HEIGHT_RST);
        test_random_traffic(80, TRAFFIC_SMOOTH);
        test_backpressure();

        pick_width = $urandom_range(32, 1);
        apply_settings(1'b0, 6'(pick_width), 10'($urandom_range(pick_width * 12, 1)),
                       7'($urandom));
        test_random_traffic(80, TRAFFIC_SENDER_GAPS);

        apply_settings(1'b1, 6'($urandom), 10'($urandom), 7'($urandom_range(12, 1)));
        test_random_traffic(80, TRAFFIC_RECEIVER_STALLS);

        apply_settings(1'b1, 6'($urandom), 10'($urandom), 7'($urandom_range(24, 1)));
        test_random_traffic(70, TRAFFIC_BOTH);

        // Extreme settings get short runs since every glyph is up to 64 rows.
        apply_settings(1'b0, 6'd1, 10'd512, 7'd64);
        test_random_traffic(25, TRAFFIC_RECEIVER_STALLS);
        apply_settings(1'b1, 6'd32, 10'd1, 7'd64);
        test_random_traffic(20, TRAFFIC_SENDER_GAPS);
        apply_settings(1'b0, 6'd32, 10'd1, 7'd1);
        test_random_traffic(15, TRAFFIC_SMOOTH);
        apply_settings(1'b0, 6'($urandom_range(63, 33)), 10'($urandom_range(1023, 513)),
                       7'($urandom_range(127, 65)));
        test_random_traffic(15, TRAFFIC_BOTH);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_packed_glyph_row_unpacker passed");
        else
            $display("tb_packed_glyph_row_unpacker failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #TIMEOUT_NS;
        $display("tb_packed_glyph_row_unpacker failed");
        $finish;
    end

endmodule
